// ----- hw/rtl/hse_pkg.sv -----
// Shared types and constants for the Huffman symbol encoder.
// No dependencies; imported by huffman_symbol_encoder.
`default_nettype none

package hse_pkg;

  localparam int SymbolsDef    = 256;
  localparam int MaxCodeLenDef = 16;

  localparam int SYM_W  = 8;
  localparam int LEN_W  = 5;
  localparam int CODE_W = 16;
  localparam int BYTE_W = 8;
  localparam int ENTRY_W = LEN_W + CODE_W;

  typedef logic [1:0]        op_t;
  typedef logic [SYM_W-1:0]  sym_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [BYTE_W-1:0] byte_t;

  localparam op_t OP_WRITE = 2'd0;
  localparam op_t OP_ENC   = 2'd1;
  localparam op_t OP_FLUSH = 2'd2;

  // one queued result beat
  typedef struct packed {
    byte_t data;
    logic  last;
    logic  err;
  } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/huffman_symbol_encoder.sv -----
// Huffman symbol encoder: code table memory, bit packer and result queue.
// Depends on hse_pkg.
`default_nettype none

// Usage:
//   Input channel (in_valid / in_stall) carries op, symbol, code_length and
//   code_bits. op WRITE stores a table entry and always answers with one beat
//   (out_byte 0, length_error set if the length is over the limit). op ENC
//   appends the symbol's code LSB-first and gives 0, 1 or 2 packed bytes.
//   op FLUSH gives the pending partial byte, right-aligned, if any.
//   out_last_of_run marks the final beat caused by one input item.
//   Timing: one item accepted per cycle while in_stall is low. The table
//   is read into rd_data_r at acceptance, the packer stage works from that
//   register and its beats enter a 4-entry result queue; out_valid rises
//   once the packer stage has pushed a beat into the queue. The result port
//   drains one beat per cycle while out_stall is low, so items producing two
//   bytes are taken no faster than their beats drain while the queue is full.
//   Stall: while out_stall is high the queue holds; once fewer than two slots
//   are free the packer stage waits and in_stall rises.
//   Reset clears the bit accumulator, pending count and queue. The code table
//   is not cleared; entries must be written before they are encoded.
module huffman_symbol_encoder #(
  parameter int SYMBOLS      = hse_pkg::SymbolsDef,
  parameter int MAX_CODE_LEN = hse_pkg::MaxCodeLenDef
) (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  output                     logic in_stall,
  input  wire  hse_pkg::op_t   in_op,
  input  wire  hse_pkg::sym_t  in_symbol,
  input  wire  hse_pkg::len_t  in_code_length,
  input  wire  hse_pkg::code_t in_code_bits,
  output                     logic out_valid,
  input  wire                logic out_stall,
  output       hse_pkg::byte_t out_byte,
  output                     logic out_last_of_run,
  output                     logic out_length_error
);
  import hse_pkg::*;

  localparam int AW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  // code table
  logic [ENTRY_W-1:0] mem [SYMBOLS];
  logic [ENTRY_W-1:0] rd_data_r;

  // packer stage
  logic s1_v_r;
  op_t  s1_op_r;
  logic s1_sym_ok_r;
  logic s1_err_r;

  // bit accumulator
  byte_t    acc_r, acc_nxt;
  logic [2:0] pend_r, pend_nxt;

  // result queue
  res_t           q_r [QDEPTH];
  logic [QAW-1:0] head_r, tail_r;
  logic [QAW:0]   cnt_r, cnt_nxt;

  logic accept, s1_go, pop, sym_ok, len_bad;
  logic [QAW:0] space;
  logic [1:0]   n_res;
  res_t         res0, res1;

  logic [LEN_W-1:0] clen;
  code_t            cmask;
  logic [22:0]      cat, shifted;
  logic [4:0]       total;
  logic [1:0]       nbytes;

  assign pop   = (cnt_r != '0) && !out_stall;
  assign space = (QAW+1)'(QDEPTH) - cnt_r + {{QAW{1'b0}}, pop};
  assign s1_go = s1_v_r && (space >= (QAW+1)'(2));
  assign in_stall = s1_v_r && !s1_go;
  assign accept   = in_valid && !in_stall;

  assign sym_ok  = {1'b0, in_symbol} < 9'(SYMBOLS);
  assign len_bad = ({1'b0, in_code_length} > 6'(MAX_CODE_LEN))
                || (in_code_length > LEN_W'(CODE_W));

  always_ff @(posedge clk) begin
    if (accept && in_op == OP_WRITE && sym_ok && !len_bad) begin
      mem[in_symbol[AW-1:0]] <= {in_code_length, in_code_bits};
    end
    if (accept && in_op == OP_ENC) begin
      rd_data_r <= mem[in_symbol[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r     <= in_op;
      s1_sym_ok_r <= sym_ok;
      s1_err_r    <= len_bad;
    end
  end

  // packing: pending bits sit low, new code lands above them
  always_comb begin
    clen    = (rd_data_r[ENTRY_W-1:CODE_W] > LEN_W'(CODE_W))
            ? LEN_W'(CODE_W) : rd_data_r[ENTRY_W-1:CODE_W];
    cmask   = ~(code_t'({CODE_W{1'b1}}) << clen);
    cat     = {15'b0, acc_r} | ({7'b0, rd_data_r[CODE_W-1:0] & cmask} << pend_r);
    total   = {2'b0, pend_r} + clen;
    nbytes  = total[4] ? 2'd2 : (total[3] ? 2'd1 : 2'd0);
    shifted = cat >> {nbytes, 3'b000};
  end

  always_comb begin
    n_res    = 2'd0;
    res0     = '{data: '0, last: 1'b1, err: 1'b0};
    res1     = '{data: cat[15:8], last: 1'b1, err: 1'b0};
    acc_nxt  = acc_r;
    pend_nxt = pend_r;
    unique case (s1_op_r)
      OP_WRITE: begin
        n_res = 2'd1;
        res0  = '{data: '0, last: 1'b1, err: s1_err_r};
      end
      OP_ENC: begin
        if (s1_sym_ok_r) begin
          n_res    = nbytes;
          res0     = '{data: cat[7:0], last: (nbytes == 2'd1), err: 1'b0};
          pend_nxt = total[2:0];
          acc_nxt  = shifted[7:0] & ~(8'hFF << total[2:0]);
        end
      end
      OP_FLUSH: begin
        if (pend_r != '0) begin
          n_res    = 2'd1;
          res0     = '{data: acc_r, last: 1'b1, err: 1'b0};
          acc_nxt  = '0;
          pend_nxt = '0;
        end
      end
      default: begin
        n_res = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pend_r <= '0;
    end else if (s1_go) begin
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
    end
  end

  // result queue, up to two pushes and one pop per cycle
  always_comb begin
    cnt_nxt = cnt_r - {{QAW{1'b0}}, pop};
    if (s1_go) begin
      cnt_nxt = cnt_nxt + {1'b0, n_res};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (pop) begin
        head_r <= head_r + QAW'(1);
      end
      if (s1_go) begin
        tail_r <= tail_r + n_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && n_res != 2'd0) begin
      q_r[tail_r] <= res0;
    end
    if (s1_go && n_res == 2'd2) begin
      q_r[tail_r + QAW'(1)] <= res1;
    end
  end

  assign out_valid        = (cnt_r != '0);
  assign out_byte         = q_r[head_r].data;
  assign out_last_of_run  = q_r[head_r].last;
  assign out_length_error = q_r[head_r].err;

endmodule

`default_nettype wire

// ----- dv/tb_huffman_symbol_encoder.sv -----
// Testbench for huffman_symbol_encoder: directed and random table writes,
// encodes and flushes, checked beat by beat against an in-bench packer model.
// Depends on hse_pkg and the huffman_symbol_encoder RTL.

module tb_huffman_symbol_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import hse_pkg::*;

  localparam op_t OP_UNUSED = 2'd3;
  localparam int  MAX_LEN   = MaxCodeLenDef;
  localparam int  DRAIN_CYCLES = 16;
  localparam int  MAX_PRINTS = 40;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  op_t    in_op;
  sym_t   in_symbol;
  len_t   in_code_length;
  code_t  in_code_bits;
  logic   out_valid;
  logic   out_stall;
  byte_t  out_byte;
  logic   out_last_of_run;
  logic   out_length_error;

  // table and packer state as seen by the testbench
  len_t   code_len_tab [256];
  code_t  code_val_tab [256];
  bit     entry_written [256];
  sym_t   written_syms [$];
  byte_t  pack_acc;
  int     pack_cnt;

  res_t   expected_beats [$];
  int     mismatch_count;
  int     sender_idle_pct;
  int     receiver_stall_pct;

  huffman_symbol_encoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_symbol        (in_symbol),
    .in_code_length   (in_code_length),
    .in_code_bits     (in_code_bits),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last_of_run  (out_last_of_run),
    .out_length_error (out_length_error)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Computes the beats one accepted item produces and updates the packer state.
  function automatic void pack_expected_bytes(op_t op, sym_t sym, len_t len, code_t bits);
    logic [23:0] window;
    code_t       used;
    int          total;
    int          nbytes;
    bit          too_long;
    case (op)
      OP_WRITE: begin
        too_long = (len > MAX_LEN);
        if (!too_long) begin
          code_len_tab[sym] = len;
          code_val_tab[sym] = bits;
          if (!entry_written[sym]) written_syms.push_back(sym);
          entry_written[sym] = 1'b1;
        end
        expected_beats.push_back('{data: 8'h00, last: 1'b1, err: too_long});
      end
      OP_ENC: begin
        used = code_val_tab[sym] & code_t'((32'd1 << code_len_tab[sym]) - 32'd1);
        window = 24'(pack_acc) | (24'(used) << pack_cnt);
        total = pack_cnt + int'(code_len_tab[sym]);
        nbytes = total / 8;
        for (int i = 0; i < nbytes; i++) begin
          expected_beats.push_back('{data: window[7:0], last: (i == nbytes - 1), err: 1'b0});
          window = window >> 8;
        end
        pack_cnt = total % 8;
        pack_acc = window[7:0] & byte_t'((16'd1 << pack_cnt) - 16'd1);
      end
      OP_FLUSH: begin
        if (pack_cnt != 0) begin
          expected_beats.push_back('{data: pack_acc, last: 1'b1, err: 1'b0});
          pack_acc = '0;
          pack_cnt = 0;
        end
      end
      default: ;
    endcase
  endfunction

  // Drives one item and holds it until the block takes it.
  task automatic send_item(input op_t op, input sym_t sym, input len_t len, input code_t bits);
    if (sender_idle_pct > 0) begin
      while ($urandom_range(99) < sender_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_op          <= op;
    in_symbol      <= sym;
    in_code_length <= len;
    in_code_bits   <= bits;
    do @(posedge clk); while (in_stall);
    pack_expected_bytes(op, sym, len, bits);
  endtask

  always @(posedge clk) begin
    out_stall <= (receiver_stall_pct > 0) && ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat byte=%02h last=%0b err=%0b",
                                  out_byte, out_last_of_run, out_length_error));
      end else begin
        want = expected_beats.pop_front();
        if (out_byte !== want.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
        if (out_last_of_run !== want.last)
          report_mismatch($sformatf("out_last_of_run %0b, want %0b",
                                    out_last_of_run, want.last));
        if (out_length_error !== want.err)
          report_mismatch($sformatf("out_length_error %0b, want %0b",
                                    out_length_error, want.err));
      end
    end
  end

  // Mostly encodes of known symbols, with table updates, flushes and noise mixed in.
  task automatic run_random_items(input int count);
    int    pick;
    sym_t  sym;
    len_t  len;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 60 && written_syms.size() > 0) begin
        sym = written_syms[$urandom_range(written_syms.size() - 1)];
        send_item(OP_ENC, sym, len_t'($urandom), code_t'($urandom));
      end else if (pick < 85) begin
        if ($urandom_range(9) == 0) len = len_t'($urandom_range(31, MAX_LEN + 1));
        else len = len_t'($urandom_range(MAX_LEN));
        send_item(OP_WRITE, sym_t'($urandom), len, code_t'($urandom));
      end else if (pick < 96) begin
        send_item(OP_FLUSH, sym_t'($urandom), len_t'($urandom), code_t'($urandom));
      end else begin
        send_item(OP_UNUSED, sym_t'($urandom), len_t'($urandom), code_t'($urandom));
        n--;  // ignored by the block, does not count
      end
    end
  endtask

  task automatic test_directed_cases();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_item(OP_FLUSH, 8'd0,   5'd0,  16'h0000);  // nothing pending
    send_item(OP_WRITE, 8'd0,   5'd0,  16'hFFFF);  // zero-length code
    send_item(OP_ENC,   8'd0,   5'd0,  16'h0000);
    send_item(OP_WRITE, 8'd255, 5'd16, 16'hA5C3);
    send_item(OP_WRITE, 8'd1,   5'd3,  16'hFFFD);  // bits above length must not leak
    send_item(OP_WRITE, 8'd128, 5'd1,  16'h0001);
    send_item(OP_WRITE, 8'd2,   5'd5,  16'h0015);
    send_item(OP_WRITE, 8'd2,   5'd17, 16'hFFFF);  // over limit, entry kept
    send_item(OP_WRITE, 8'd3,   5'd31, 16'h1234);
    send_item(OP_UNUSED, 8'd1,  5'd3,  16'hFFFF);
    send_item(OP_ENC,   8'd2,   5'd0,  16'h0000);
    send_item(OP_ENC,   8'd1,   5'd0,  16'h0000);  // exactly one byte
    send_item(OP_ENC,   8'd255, 5'd0,  16'h0000);  // two bytes, aligned
    send_item(OP_ENC,   8'd128, 5'd0,  16'h0000);
    send_item(OP_ENC,   8'd1,   5'd0,  16'h0000);
    send_item(OP_ENC,   8'd255, 5'd0,  16'h0000);
    send_item(OP_FLUSH, 8'd0,   5'd0,  16'h0000);
    send_item(OP_FLUSH, 8'd0,   5'd0,  16'h0000);
    send_item(OP_ENC,   8'd1,   5'd0,  16'h0000);
    send_item(OP_ENC,   8'd1,   5'd0,  16'h0000);
    send_item(OP_ENC,   8'd128, 5'd0,  16'h0000);  // seven bits pending
    send_item(OP_ENC,   8'd255, 5'd0,  16'h0000);  // longest code on a full accumulator
    send_item(OP_FLUSH, 8'd0,   5'd0,  16'h0000);
  endtask

  task automatic test_back_to_back();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    run_random_items(100);
  endtask

  task automatic test_sender_gaps();
    sender_idle_pct    = 86;
    receiver_stall_pct = 0;
    run_random_items(100);
  endtask

  task automatic test_receiver_stalls();
    sender_idle_pct    = 0;
    receiver_stall_pct = 86;
    run_random_items(100);
  endtask

  task automatic test_both_sides_idle();
    sender_idle_pct    = 11;
    receiver_stall_pct = 11;
    run_random_items(100);
  endtask

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_op              = OP_WRITE;
    in_symbol          = '0;
    in_code_length     = '0;
    in_code_bits       = '0;
    out_stall          = 1'b0;
    pack_acc           = '0;
    pack_cnt           = 0;
    mismatch_count     = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    foreach (entry_written[i]) begin
      entry_written[i] = 1'b0;
      code_len_tab[i]  = '0;
      code_val_tab[i]  = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_sides_idle();

    in_valid <= 1'b0;
    receiver_stall_pct = 0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout, %0d beats still expected", expected_beats.size());
    $display("FAILURE");
    $finish;
  end

endmodule
